// File: rtl/itrd_pkg.sv
// Shared constants and the digit-to-ASCII mapping for the radix digit converter.
// Used by itrd_divider, integer_to_radix_digits_unit, itrd_checker and the bench; depends on nothing.
package itrd_pkg;

    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int OUT_W     = 8;
    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 36;
    localparam int DEC_DIGITS = 10;
    localparam int TOP_DIGIT  = 35;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

    // 0-9 then A-Z; anything past Z saturates at Z
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [RADIX_W-1:0] dc;
        logic [CHAR_W-1:0]  ch;
        dc = (d > RADIX_W'(TOP_DIGIT)) ? RADIX_W'(TOP_DIGIT) : d;
        if (dc < RADIX_W'(DEC_DIGITS))
        begin
            ch = CHAR_ZERO + CHAR_W'(dc);
        end
        else
        begin
            ch = CHAR_A + CHAR_W'(dc - RADIX_W'(DEC_DIGITS));
        end
        return ch;
    endfunction

    function automatic logic radix_is_bad(input logic [RADIX_W-1:0] r);
        return (r < RADIX_W'(RADIX_MIN)) || (r > RADIX_W'(RADIX_MAX));
    endfunction

endpackage

// File: rtl/itrd_divider.sv
// Restoring divider, one quotient bit per cycle, divides a value by a radix.
// Depends on itrd_pkg.
module itrd_divider import itrd_pkg::*; #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [RADIX_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RADIX_W:0]      trial;
    logic [RADIX_W:0]      diff;
    logic                  fits;

    assign trial = {rem_reg, work_reg[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one quotient bit, keep the partial remainder below the divisor
            work_next = {work_reg[VALUE_BITS-2:0], fits};
            rem_next  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/integer_to_radix_digits_unit.sv
// Top level of the radix digit converter: sequencer, digit store, output register.
// Depends on itrd_pkg and itrd_divider.
//
// Usage:
//   Input stream s_*: one word carries a number and a radix (2..36). The block
//   answers on the output stream m_* with the ASCII digits of the number, most
//   significant first, one word per digit, tlast on the final digit. Zero gives
//   the single digit '0'. A radix outside 2..36 gives one word with tuser set,
//   tdata zero and tlast set.
//   Flow: each digit costs one pass of the shared bit-serial divider; once all
//   digits are stored, each is read back from the digit store (ST_READ) and
//   loaded into the output register (ST_EMIT), most significant first.
//   s_tready is high only while the sequencer is idle, so one word is in work
//   at a time; the final output word may still wait while the next input is
//   taken.
//   Reset clears the sequencer, the output valid and the counters; the digit
//   store is not cleared since each conversion writes its digits before
//   reading them. A stalled receiver (m_tready low) holds the output word
//   and freezes the read-back of further digits.
module integer_to_radix_digits_unit import itrd_pkg::*; #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // s_tdata from bit 0: number[VALUE_BITS-1:0], radix[5:0], zero fill
    input  logic [((VALUE_BITS + RADIX_W + 7) / 8)*8-1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // m_tdata from bit 0: digit_char[6:0], zero fill
    output logic [OUT_W-1:0]                            m_tdata,
    output logic                                        m_tlast,
    // m_tuser: bad_radix
    output logic                                        m_tuser
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DIV_GO   = 6'b000010,
        ST_DIV_WAIT = 6'b000100,
        ST_READ     = 6'b001000,
        ST_EMIT     = 6'b010000,
        ST_ERROR    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] quotient_reg, quotient_next;
    logic [CNT_W-1:0]      digit_count_reg, digit_count_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [RADIX_W-1:0]    rd_data_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_bad_reg, out_bad_next;

    logic [RADIX_W-1:0]    digit_store [MAX_DIGITS];
    logic                  store_we;

    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [RADIX_W-1:0]    div_rem;

    logic [VALUE_BITS-1:0] in_number;
    logic [RADIX_W-1:0]    in_radix;
    logic                  in_accept;
    logic                  slot_free;

    assign in_number = s_tdata[VALUE_BITS-1:0];
    assign in_radix  = s_tdata[VALUE_BITS +: RADIX_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    itrd_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (quotient_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next       = state_reg;
        quotient_next    = quotient_reg;
        digit_count_next = digit_count_reg;
        radix_next       = radix_reg;
        rd_idx_next      = rd_idx_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_bad_next     = out_bad_reg;
        store_we         = 1'b0;
        div_start        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    radix_next = in_radix;
                    if (radix_is_bad(in_radix))
                    begin
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        quotient_next    = in_number;
                        digit_count_next = '0;
                        state_next       = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    store_we         = 1'b1;
                    quotient_next    = div_quot;
                    digit_count_next = digit_count_reg + CNT_W'(1);
                    // stop on a zero quotient or a full store
                    if (div_quot == '0 || digit_count_reg == CNT_W'(MAX_DIGITS - 1))
                    begin
                        rd_idx_next = digit_count_reg[IDX_W-1:0];
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_char(rd_data_reg);
                    out_last_next  = (rd_idx_reg == '0);
                    out_bad_next   = 1'b0;
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            ST_ERROR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            quotient_reg    <= '0;
            digit_count_reg <= '0;
            radix_reg       <= '0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            quotient_reg    <= quotient_next;
            digit_count_reg <= digit_count_next;
            radix_reg       <= radix_next;
            rd_idx_reg      <= rd_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    // digit store: remainders land least significant first, read back from the top
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            digit_store[digit_count_reg[IDX_W-1:0]] <= div_rem;
        end
        rd_data_reg <= digit_store[rd_idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - CHAR_W){1'b0}}, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

endmodule

// File: rtl/itrd_checker.sv
// Port-level checks for integer_to_radix_digits_unit, attached by bind.
// Depends on itrd_pkg.
module itrd_checker import itrd_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast,
    input logic             m_tuser
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output word changed while stalled");

    // an error word is a single, empty, final word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
        else $error("error word malformed");

    // a digit word carries 0-9 or A-Z
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            (m_tdata >= 8'h30 && m_tdata <= 8'h39) || (m_tdata >= 8'h41 && m_tdata <= 8'h5A))
        else $error("digit word outside 0-9/A-Z");

    // one word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: tb/integer_to_radix_digits_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_to_radix_digits_unit: random and directed conversions,
// checked word by word against a predictor of the digit sequence.
// Depends on itrd_pkg and the unit under test.
module integer_to_radix_digits_unit_tb;
    import itrd_pkg::*;

    localparam int VALUE_BITS     = 31;
    localparam int MAX_DIGITS     = 31;
    localparam int IN_W           = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 280;
    localparam int PHASE_ITEMS    = 40;
    localparam int MAX_GAP        = 11;
    localparam int TAIL_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam logic [VALUE_BITS-1:0] NUM_MAX = {VALUE_BITS{1'b1}};

    typedef struct {
        logic [VALUE_BITS-1:0] number;
        logic [RADIX_W-1:0]    radix;
        int unsigned           gap;
        bit                    drain;
    } conv_req_t;

    typedef struct {
        logic [OUT_W-1:0] data;
        logic             last;
        logic             bad;
    } digit_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // s_tdata from bit 0: number[30:0], radix[5:0], zero fill
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // m_tdata from bit 0: digit_char[6:0], zero fill
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    // m_tuser: bad_radix
    logic             m_tuser;

    integer_to_radix_digits_unit #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    conv_req_t   pending_numbers[$];
    digit_word_t digits_due[$];

    // predictor state
    logic [RADIX_W-1:0]    model_rem[MAX_DIGITS];
    logic [VALUE_BITS-1:0] model_quot = '0;
    logic [RADIX_W-1:0]    model_ndig = '0;
    logic [RADIX_W-1:0]    model_radix = '0;

    int unsigned errors = 0;
    int unsigned numbers_in = 0;
    int unsigned words_out = 0;
    int unsigned bad_in = 0;
    int unsigned idle_cycles = 0;

    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    bit          have_cur = 1'b0;
    conv_req_t   cur;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned words_in_mode = 0;
    bit          rx_calm = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at word %0d: got %0h, expected %0h",
                 what, words_out, got, want);
        errors++;
    endtask

    task automatic predict_digits(input logic [VALUE_BITS-1:0] num,
                                  input logic [RADIX_W-1:0] rad);
        int          n;
        int          k;
        logic [RADIX_W-1:0] d;
        digit_word_t w;
        model_radix = rad;
        if (rad < RADIX_MIN || rad > RADIX_MAX)
        begin
            // store, quotient and count stay as they were
            w.data = '0;
            w.last = 1'b1;
            w.bad  = 1'b1;
            digits_due.push_back(w);
        end
        else
        begin
            model_quot = num;
            n = 0;
            do
            begin
                model_rem[n] = RADIX_W'(model_quot % rad);
                model_quot   = model_quot / rad;
                n++;
            end while (model_quot != 0 && n < MAX_DIGITS);
            model_ndig = RADIX_W'(n);
            for (k = 0; k < n; k++)
            begin
                d = model_rem[n - 1 - k];
                if (d > RADIX_W'(TOP_DIGIT))
                begin
                    d = RADIX_W'(TOP_DIGIT);
                end
                if (d < RADIX_W'(DEC_DIGITS))
                begin
                    w.data = OUT_W'(CHAR_ZERO + CHAR_W'(d));
                end
                else
                begin
                    w.data = OUT_W'(CHAR_A + CHAR_W'(d - RADIX_W'(DEC_DIGITS)));
                end
                w.last = (k + 1 == n);
                w.bad  = 1'b0;
                digits_due.push_back(w);
            end
        end
    endtask

    task automatic add_number(input logic [VALUE_BITS-1:0] num, input logic [RADIX_W-1:0] rad,
                              input int unsigned gap, input bit drain);
        conv_req_t r;
        r.number = num;
        r.radix  = rad;
        r.gap    = gap;
        r.drain  = drain;
        pending_numbers.push_back(r);
    endtask

    // input side: wait for a drain if asked, count down the gap, then present the next word
    always @(negedge clk)
    begin : drive_numbers
        logic nxt_valid;
        nxt_valid = s_tvalid;
        if (rst_n)
        begin
            if (s_tvalid && in_taken)
            begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (!have_cur && pending_numbers.size() != 0)
                begin
                    cur      = pending_numbers.pop_front();
                    have_cur = 1'b1;
                    gap_left = cur.gap;
                end
                if (have_cur)
                begin
                    if (cur.drain && digits_due.size() != 0)
                    begin
                        // hold until the block has handed back everything
                    end
                    else if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        s_tdata   <= IN_W'({cur.radix, cur.number});
                        nxt_valid = 1'b1;
                        have_cur  = 1'b0;
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // output side: draw a random stall after every accepted word, none while the receiver is calm
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                words_in_mode++;
                if (words_in_mode >= 32)
                begin
                    words_in_mode = 0;
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        digit_word_t w;
        in_taken  <= s_tvalid && s_tready;
        out_taken <= (m_tvalid === 1'b1) && m_tready;
        if (s_tvalid && s_tready)
        begin
            predict_digits(s_tdata[VALUE_BITS-1:0], s_tdata[VALUE_BITS +: RADIX_W]);
            numbers_in++;
            if (s_tdata[VALUE_BITS +: RADIX_W] < RADIX_MIN ||
                s_tdata[VALUE_BITS +: RADIX_W] > RADIX_MAX)
            begin
                bad_in++;
            end
        end
        if ((m_tvalid === 1'b1) && m_tready)
        begin
            if (digits_due.size() == 0)
            begin
                report_mismatch("unexpected word", 32'(m_tdata), '0);
            end
            else
            begin
                w = digits_due.pop_front();
                if (m_tdata !== w.data)
                begin
                    report_mismatch("digit_char", 32'(m_tdata), 32'(w.data));
                end
                if (m_tlast !== w.last)
                begin
                    report_mismatch("last_digit", 32'(m_tlast), 32'(w.last));
                end
                if (m_tuser !== w.bad)
                begin
                    report_mismatch("bad_radix", 32'(m_tuser), 32'(w.bad));
                end
            end
            words_out++;
        end
        if ((s_tvalid && s_tready) || ((m_tvalid === 1'b1) && m_tready) || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d words still due",
                         idle_cycles, digits_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          p;
        int          i;
        int unsigned sel;
        int unsigned len;
        logic [VALUE_BITS-1:0] num;
        logic [RADIX_W-1:0]    rad;
        bit          calm;

        // directed: zero, full-width values, radix extremes, invalid radices
        add_number('0, 6'd10, $urandom_range(0, MAX_GAP), 1'b0);
        add_number('0, 6'd2, $urandom_range(0, MAX_GAP), 1'b0);
        add_number('0, 6'd36, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(NUM_MAX, 6'd2, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(NUM_MAX, 6'd36, 0, 1'b1);
        add_number(NUM_MAX, 6'd10, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(NUM_MAX, 6'd16, 0, 1'b0);
        add_number(NUM_MAX, 6'd3, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd1, 6'd36, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd35, 6'd36, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd36, 6'd36, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd1295, 6'd36, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd9, 6'd10, 0, 1'b0);
        add_number(31'd10, 6'd10, 0, 1'b0);
        add_number(NUM_MAX, 6'd0, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd12345, 6'd1, $urandom_range(0, MAX_GAP), 1'b0);
        add_number('0, 6'd37, 0, 1'b0);
        add_number(NUM_MAX, 6'd63, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd255, 6'd8, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'h4000_0000, 6'd2, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'd15, 6'd16, 0, 1'b1);
        add_number(NUM_MAX, 6'd35, $urandom_range(0, MAX_GAP), 1'b0);
        add_number(31'h2AAA_AAAA, 6'd2, $urandom_range(0, MAX_GAP), 1'b0);

        // random phases; some run with no gaps, each opens after a full drain
        for (p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            calm = (p % 3 == 1);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 12)
                begin
                    case ($urandom_range(0, 3))
                        0: rad = 6'd0;
                        1: rad = 6'd1;
                        default: rad = RADIX_W'($urandom_range(RADIX_MAX + 1, 63));
                    endcase
                end
                else if (sel < 22)
                begin
                    rad = ($urandom_range(0, 1) == 0) ? RADIX_W'(RADIX_MIN) : RADIX_W'(RADIX_MAX);
                end
                else
                begin
                    rad = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
                end
                case ($urandom_range(0, 4))
                    0: num = VALUE_BITS'($urandom_range(0, 40));
                    1: num = VALUE_BITS'($urandom);
                    default:
                    begin
                        len = $urandom_range(1, VALUE_BITS);
                        num = VALUE_BITS'($urandom & ((32'd1 << len) - 1));
                    end
                endcase
                add_number(num, rad, calm ? 0 : $urandom_range(0, MAX_GAP), i == 0);
            end
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || have_cur || s_tvalid)
        begin
            @(posedge clk);
        end
        while (digits_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("converted %0d numbers (%0d with a radix outside 2..36) into %0d checked words",
                 numbers_in, bad_in, words_out);
        $display("covered zero, full-width values, radix 2 and 36, bursts and stalls on both sides");
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/itrd_pkg.sv
rtl/itrd_divider.sv
rtl/integer_to_radix_digits_unit.sv
rtl/itrd_checker.sv
tb/integer_to_radix_digits_unit_tb.sv
